>>> rtl/cmf_pkg.sv
// cmf_pkg: shared types and constants of the 3x3 mask filter.
// Mask coefficients, reciprocal table, register indexes, result tag.
// No dependencies.
package cmf_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int ROW_BITS    = 12;
  localparam int POS_BITS    = 12;
  localparam int SUM_W       = 16;  // signed 3x3 sum, covers every mask
  localparam int LP_W        = 13;  // low-pass sums stay below 8192
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = LP_W + RECIP_W;
  localparam int CFG_W       = 13;

  typedef enum logic [2:0] {
    REG_MASK_SELECT     = 3'd0,
    REG_IMAGE_WIDTH     = 3'd1,
    REG_IMAGE_HEIGHT    = 3'd2,
    REG_BYTES_PER_PIXEL = 3'd3,
    REG_MAX_LEVEL       = 3'd4
  } reg_index_t;

  localparam logic [2:0] MASK_FIRST_HIGHPASS = 3'd5;

  // row-major 3x3 coefficients, left column is the oldest pixel
  localparam logic signed [4:0] KERNEL [8][9] = '{
    '{ 5'sd0,  5'sd1,  5'sd0,  5'sd1,  5'sd2,  5'sd1,  5'sd0,  5'sd1,  5'sd0},
    '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
    '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd2,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
    '{ 5'sd1,  5'sd4,  5'sd1,  5'sd4, 5'sd12,  5'sd4,  5'sd1,  5'sd4,  5'sd1},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{ 5'sd1, -5'sd2,  5'sd1, -5'sd2,  5'sd5, -5'sd2,  5'sd1, -5'sd2,  5'sd1}
  };

  // ceil(2^17 / d); exact truncated quotient for sums below 2^13
  function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] mask);
    logic [RECIP_W-1:0] r;
    case (mask)
      3'd0:    r = 18'd21846;  // /6
      3'd1:    r = 18'd14564;  // /9
      3'd2:    r = 18'd13108;  // /10
      3'd3:    r = 18'd8192;   // /16
      3'd4:    r = 18'd4096;   // /32
      default: r = 18'd0;      // high-pass, bypassed
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [POS_BITS-1:0] pos;
    logic                last;
  } tag_t;

endpackage

>>> rtl/cmf_ram.sv
// cmf_ram: generic simple dual-port RAM, one write and one registered read.
// Uses no package.
module cmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cmf_addr.sv
// cmf_addr: raster position counters, line store address and result tag.
// Depends on cmf_pkg.
module cmf_addr #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              sof,
  input  logic [10:0]       image_width,
  input  logic [12:0]       image_height,
  input  logic [2:0]        bytes_per_pixel,
  output logic [ADDR_W-1:0] idx,
  output logic [CH_W-1:0]   ch,
  output logic              emit,
  output cmf_pkg::tag_t     tag
);

  localparam int IW    = ADDR_W + 3;
  localparam int POS_W = (ADDR_W > cmf_pkg::POS_BITS) ? ADDR_W : cmf_pkg::POS_BITS;
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
  localparam logic [2:0]  MAXC = 3'(MAX_CHANNELS);

  logic [COL_W-1:0] col;
  logic [11:0]      row;
  logic [CH_W-1:0]  chc;
  logic [COL_W-1:0] cur_col;
  logic [11:0]      cur_row;
  logic [CH_W-1:0]  cur_ch;
  logic [13:0]      w_eff;
  logic [12:0]      h_eff;
  logic [2:0]       bpp;
  logic [COL_W-1:0] w_m1;
  logic [11:0]      h_m1;
  logic [2:0]       bpp_m1;
  logic             ch_wrap, col_wrap, row_wrap;
  logic [IW-1:0]    idx_full;

  // effective geometry, clamped to the supported range
  always_comb begin
    if ({3'b0, image_width} < 14'd3) w_eff = 14'd3;
    else if ({3'b0, image_width} > MAXW) w_eff = MAXW;
    else w_eff = {3'b0, image_width};
    if (image_height < 13'd3) h_eff = 13'd3;
    else if (image_height > 13'd4096) h_eff = 13'd4096;
    else h_eff = image_height;
    if (bytes_per_pixel < 3'd1) bpp = 3'd1;
    else if (bytes_per_pixel > MAXC) bpp = MAXC;
    else bpp = bytes_per_pixel;
  end

  assign w_m1   = COL_W'(w_eff - 14'd1);
  assign h_m1   = 12'(h_eff - 13'd1);
  assign bpp_m1 = bpp - 3'd1;

  assign cur_col = sof ? '0 : col;
  assign cur_row = sof ? '0 : row;
  assign cur_ch  = sof ? '0 : chc;

  assign ch_wrap  = 3'(cur_ch) >= bpp_m1;
  assign col_wrap = cur_col >= w_m1;
  assign row_wrap = cur_row >= h_m1;

  assign idx_full = IW'(cur_col) * IW'(bpp) + IW'(cur_ch);
  assign idx      = idx_full[ADDR_W-1:0];
  assign ch       = cur_ch;

  assign emit     = (cur_row >= 12'd2) && (cur_col >= COL_W'(2));
  assign tag.row  = cur_row - 12'd1;
  assign tag.pos  = cmf_pkg::POS_BITS'(POS_W'(idx) - POS_W'(bpp));
  assign tag.last = row_wrap && col_wrap && ch_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      chc <= '0;
    end else if (accept) begin
      if (ch_wrap) begin
        chc <= '0;
        if (col_wrap) begin
          col <= '0;
          row <= row_wrap ? 12'd0 : cur_row + 12'd1;
        end else begin
          col <= cur_col + COL_W'(1);
          row <= cur_row;
        end
      end else begin
        chc <= cur_ch + CH_W'(1);
        col <= cur_col;
        row <= cur_row;
      end
    end
  end

endmodule

>>> rtl/cmf_scale.sv
// cmf_scale: divides the 3x3 sum by the mask divisor, clamps, holds output.
// Reciprocal multiply stage, then clamp into the output register. Uses cmf_pkg.
module cmf_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cmf_pkg::SUM_W-1:0]  in_sum,
  input  cmf_pkg::tag_t                     in_tag,
  input  logic [2:0]                        mask_select,
  input  logic [7:0]                        max_level,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,
  output logic                              m_tlast
);

  localparam int PW = cmf_pkg::PROD_W;

  logic                             v3;
  logic [PW-1:0]                    s3_prod;
  logic signed [cmf_pkg::SUM_W-1:0] s3_sum;
  logic                             s3_hp;
  cmf_pkg::tag_t                    s3_tag;
  logic                             en_out;
  logic [PW-1:0]                    prod_c;
  logic signed [cmf_pkg::SUM_W-1:0] qv;
  logic [7:0]                       filt;

  assign en_out   = !m_tvalid || m_tready;
  assign in_ready = !v3 || en_out;

  assign prod_c = PW'(in_sum[cmf_pkg::LP_W-1:0])
                * PW'(cmf_pkg::recip_of(mask_select));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (in_ready) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s3_prod <= prod_c;
      s3_sum  <= in_sum;
      s3_hp   <= mask_select >= cmf_pkg::MASK_FIRST_HIGHPASS;
      s3_tag  <= in_tag;
    end
  end

  // high-pass masks have divisor one and may go negative
  always_comb begin
    if (s3_hp) qv = s3_sum;
    else qv = $signed(cmf_pkg::SUM_W'(s3_prod[PW-1:cmf_pkg::RECIP_SHIFT]));
    if (qv < 0) filt = 8'd0;
    else if (qv > $signed({8'b0, max_level})) filt = max_level;
    else filt = qv[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && v3) begin
      m_tdata <= {s3_tag.pos, s3_tag.row, filt};
      m_tlast <= s3_tag.last;
    end
  end

endmodule

>>> rtl/conv3x3_mask_filter_unit.sv
// conv3x3_mask_filter_unit: streaming 3x3 mask filter over interleaved channels.
// Pipeline: a result passes the stage 1, stage 2, scale and output registers.
// Throughput: one sample per cycle without output stalls; the line store read at transfer
//   and its write-back as stage 1 leaves (forwarded on an address repeat) set that pace.
// Reset (rst, synchronous): clears counters, window, registers and valid flags;
//   line stores are not cleared and read as garbage until written.
// Depends on cmf_pkg, cmf_ram, cmf_addr, cmf_scale.
module conv3x3_mask_filter_unit #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic        s_tuser,   // [0] start_of_frame
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] filtered, [19:8] out_row, [31:20] out_sample_pos
  output logic        m_tlast    // last_of_frame
);

  localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SB          = cmf_pkg::SAMPLE_BITS;

  // ---------------------------------------------------------------- config
  logic [2:0]  mask_select;
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  bytes_per_pixel;
  logic [7:0]  max_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_select     <= 3'd1;
      image_width     <= 11'd1024;
      image_height    <= 13'd1024;
      bytes_per_pixel <= 3'd1;
      max_level       <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        cmf_pkg::REG_MASK_SELECT:     mask_select     <= cfg_data[2:0];
        cmf_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[10:0];
        cmf_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data[12:0];
        cmf_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        cmf_pkg::REG_MAX_LEVEL:       max_level       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ stage 0: transfer
  // Counters give the store address and the tag; the store read is issued here.
  logic              accept;
  logic [ADDR_W-1:0] a_idx;
  logic [CH_W-1:0]   a_ch;
  logic              a_emit;
  cmf_pkg::tag_t     a_tag;

  assign accept = s_tvalid && s_tready;

  cmf_addr #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_addr (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .sof            (s_tuser),
    .image_width    (image_width),
    .image_height   (image_height),
    .bytes_per_pixel(bytes_per_pixel),
    .idx            (a_idx),
    .ch             (a_ch),
    .emit           (a_emit),
    .tag            (a_tag)
  );

  // ------------------------------------------ stage 1: store data, window
  logic              v1;
  logic [ADDR_W-1:0] s1_idx;
  logic [CH_W-1:0]   s1_ch;
  logic [SB-1:0]     s1_smp;
  logic              s1_emit;
  cmf_pkg::tag_t     s1_tag;
  logic              s1_hit;
  logic [SB-1:0]     fwd_up, fwd_mid;
  logic [SB-1:0]     rd_up, rd_mid;
  logic [SB-1:0]     up_res, mid_res;
  logic              s1_leave;
  logic              en2;

  // Write-back happens as stage 1 leaves; a transfer in that same cycle reads
  // the old entry, so a repeated address takes the write data instead.
  assign up_res   = s1_hit ? fwd_up  : rd_up;
  assign mid_res  = s1_hit ? fwd_mid : rd_mid;
  assign s1_leave = v1 && en2;
  assign s_tready = !v1 || en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx  <= a_idx;
      s1_ch   <= a_ch;
      s1_smp  <= s_tdata;
      s1_emit <= a_emit;
      s1_tag  <= a_tag;
      s1_hit  <= s1_leave && (s1_idx == a_idx);
      fwd_up  <= mid_res;
      fwd_mid <= s1_smp;
    end
  end

  // upper store takes the old middle row, middle store the new sample
  cmf_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_upper (
    .clk  (clk),
    .we   (s1_leave),
    .waddr(s1_idx),
    .wdata(mid_res),
    .re   (accept),
    .raddr(a_idx),
    .rdata(rd_up)
  );

  cmf_ram #(.WIDTH(SB), .DEPTH(STORE_DEPTH)) u_middle (
    .clk  (clk),
    .we   (s1_leave),
    .waddr(s1_idx),
    .wdata(s1_smp),
    .re   (accept),
    .raddr(a_idx),
    .rdata(rd_mid)
  );

  // window: two older pixel columns for each row and channel
  logic [SB-1:0] win [3][2][MAX_CHANNELS];
  logic [SB-1:0] col2 [3];
  logic [SB-1:0] nb [9];

  assign col2[0] = up_res;
  assign col2[1] = mid_res;
  assign col2[2] = s1_smp;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r*3]   = win[r][0][s1_ch];
      nb[r*3+1] = win[r][1][s1_ch];
      nb[r*3+2] = col2[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
          win[r][0][k] <= '0;
          win[r][1][k] <= '0;
        end
      end
    end else if (s1_leave) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0][s1_ch] <= win[r][1][s1_ch];
        win[r][1][s1_ch] <= col2[r];
      end
    end
  end

  // mask sum over the nine taps
  logic signed [cmf_pkg::SUM_W-1:0] sum_c;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < 9; i++) begin
      sum_c = sum_c + cmf_pkg::SUM_W'($signed({1'b0, nb[i]}))
                    * cmf_pkg::SUM_W'(cmf_pkg::KERNEL[mask_select][i]);
    end
  end

  // ---------------------------------------------------- stage 2: sum reg
  logic                             v2;
  logic signed [cmf_pkg::SUM_W-1:0] s2_sum;
  cmf_pkg::tag_t                    s2_tag;
  logic                             s2_ready;

  assign en2 = !v2 || s2_ready;

  // border pixels drop out here
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1 && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      s2_sum <= sum_c;
      s2_tag <= s1_tag;
    end
  end

  // ------------------------------------------ stages 3 and 4: scale, out
  cmf_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_ready   (s2_ready),
    .in_sum     (s2_sum),
    .in_tag     (s2_tag),
    .mask_select(mask_select),
    .max_level  (max_level),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

>>> sim/conv3x3_mask_filter_unit_test.sv
`timescale 1ns / 1ps
// conv3x3_mask_filter_unit_test: self-checking bench for the streaming 3x3 mask filter.
// Directed frames, a back-pressure run, then random frames under random stalls,
// checked against an in-bench model. Depends on cmf_pkg and conv3x3_mask_filter_unit.
module conv3x3_mask_filter_unit_test;

  localparam int MAX_W        = 1024;
  localparam int MAX_CH       = 4;
  localparam int MAX_H        = 4096;
  localparam int STORE_DEPTH  = MAX_W * MAX_CH;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the pipe
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 8;     // settling margin after the last owed result is out
  localparam int MAX_REPORTS  = 100;   // keep the log short on a badly broken block

  // mask codes: five smoothing masks, then three sharpening masks
  localparam logic [2:0] MASK_DIV6     = 3'd0;
  localparam logic [2:0] MASK_DIV9     = 3'd1;
  localparam logic [2:0] MASK_DIV10    = 3'd2;
  localparam logic [2:0] MASK_DIV16    = 3'd3;
  localparam logic [2:0] MASK_DIV32    = 3'd4;
  localparam logic [2:0] MASK_SHARPEN1 = cmf_pkg::MASK_FIRST_HIGHPASS;
  localparam logic [2:0] MASK_SHARPEN2 = 3'd6;
  localparam logic [2:0] MASK_SHARPEN3 = 3'd7;

  // taps in raster order: top row first, oldest column first in each row
  localparam int COEF [8][9] = '{
    '{ 0,  1,  0,  1,  2,  1,  0,  1,  0},
    '{ 1,  1,  1,  1,  1,  1,  1,  1,  1},
    '{ 1,  1,  1,  1,  2,  1,  1,  1,  1},
    '{ 1,  2,  1,  2,  4,  2,  1,  2,  1},
    '{ 1,  4,  1,  4, 12,  4,  1,  4,  1},
    '{ 0, -1,  0, -1,  5, -1,  0, -1,  0},
    '{-1, -1, -1, -1,  9, -1, -1, -1, -1},
    '{ 1, -2,  1, -2,  5, -2,  1, -2,  1}
  };
  localparam int DIVISOR [8] = '{6, 9, 10, 16, 32, 1, 1, 1};

  // same layout as {m_tlast, m_tdata}
  typedef struct packed {
    logic                            last;
    logic [cmf_pkg::POS_BITS-1:0]    pos;
    logic [cmf_pkg::ROW_BITS-1:0]    row;
    logic [cmf_pkg::SAMPLE_BITS-1:0] level;
  } pixel_out_t;

  // one line of the directed stimulus: a register write or a sample transfer
  typedef struct {
    bit                  is_reg;
    cmf_pkg::reg_index_t idx;
    int unsigned         value;  // register value, or the sample
    logic                sof;
    bit                  typed;  // px holds a hand-computed result
    pixel_out_t          px;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [cmf_pkg::CFG_W-1:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tlast;

  conv3x3_mask_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter model state: registers at their reset values, line stores, window
  // ---------------------------------------------------------------------------
  logic [2:0]  mask_reg      = MASK_DIV9;
  logic [10:0] width_reg     = 11'd1024;
  logic [12:0] height_reg    = 13'd1024;
  logic [2:0]  bpp_reg       = 3'd1;
  logic [7:0]  level_max_reg = 8'd255;

  bit [7:0] upper_line  [STORE_DEPTH];
  bit [7:0] middle_line [STORE_DEPTH];
  bit [7:0] window      [3][2][MAX_CH];  // two older columns of each row, per channel
  int unsigned col_cnt  = 0;
  int unsigned row_cnt  = 0;
  int unsigned chan_cnt = 0;

  pixel_out_t pending_pixels[$];  // results still owed by the block, oldest first

  int  fail_count   = 0;
  int  random_items = 0;
  int  quiet_cycles = 0;
  int  idle_pct     = 0;     // chance of a gap per transfer, both sides; 0 = no idling
  bit  hold_request = 1'b0;  // asks the receiver for one long hold-off
  bit  stream_busy  = 1'b0;  // samples went in since the last drain

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Consumes one sample; returns 1 and the result when the sample completes an
  // interior pixel. Out-of-range register values are clamped on use.
  function automatic bit convolve_sample(input logic [7:0] smp, input logic sof,
                                         output pixel_out_t res);
    int unsigned w, h, b, col, ch, idx;
    int acc, r, i;
    bit [7:0] up, mid;
    bit [7:0] nb [9];
    bit hit;
    w   = clamp_to(width_reg, 3, MAX_W);
    h   = clamp_to(height_reg, 3, MAX_H);
    b   = clamp_to(bpp_reg, 1, MAX_CH);
    up  = '0;
    mid = '0;
    hit = 1'b0;
    res = '0;
    if (sof) begin
      col_cnt  = 0;
      row_cnt  = 0;
      chan_cnt = 0;
    end
    col = col_cnt;
    ch  = chan_cnt % MAX_CH;
    idx = col * b + ch;
    // the two stores shift down one row at this position
    if (idx < STORE_DEPTH) begin
      up  = upper_line[idx];
      mid = middle_line[idx];
      upper_line[idx]  = mid;
      middle_line[idx] = smp;
    end
    for (r = 0; r < 3; r++) begin
      nb[r*3]   = window[r][0][ch];
      nb[r*3+1] = window[r][1][ch];
    end
    nb[2] = up;
    nb[5] = mid;
    nb[8] = smp;
    if (row_cnt >= 2 && col >= 2) begin
      acc = 0;
      for (i = 0; i < 9; i++) acc += int'(nb[i]) * COEF[mask_reg][i];
      acc = acc / DIVISOR[mask_reg];  // truncates toward zero
      if (acc < 0) acc = 0;
      if (acc > int'(level_max_reg)) acc = int'(level_max_reg);
      res.level = acc[7:0];
      res.row   = cmf_pkg::ROW_BITS'(row_cnt - 1);
      res.pos   = cmf_pkg::POS_BITS'((col - 1) * b + ch);
      res.last  = (row_cnt >= h - 1) && (col >= w - 1) && (chan_cnt >= b - 1);
      hit = 1'b1;
    end
    for (r = 0; r < 3; r++) begin
      window[r][0][ch] = window[r][1][ch];
      window[r][1][ch] = nb[r*3+2];
    end
    // channel, then column, then row; each wraps at its end
    if (chan_cnt >= b - 1) begin
      chan_cnt = 0;
      if (col_cnt >= w - 1) begin
        col_cnt = 0;
        if (row_cnt >= h - 1) row_cnt = 0;
        else row_cnt++;
      end else begin
        col_cnt++;
      end
    end else begin
      chan_cnt++;
    end
    return hit;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // stop offering, let every owed result come out, then let the pipe settle
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write only on an idle block; junk above the register width
  // rides along and must be ignored
  task automatic write_reg(input cmf_pkg::reg_index_t idx, input int unsigned value);
    int bits;
    logic [cmf_pkg::CFG_W-1:0] data;
    if (stream_busy) begin
      quiesce();
      stream_busy = 1'b0;
    end
    case (idx)
      cmf_pkg::REG_MASK_SELECT, cmf_pkg::REG_BYTES_PER_PIXEL: bits = 3;
      cmf_pkg::REG_IMAGE_WIDTH:                               bits = 11;
      cmf_pkg::REG_IMAGE_HEIGHT:                              bits = 13;
      default:                                                bits = 8;
    endcase
    data = cmf_pkg::CFG_W'(value & ((1 << bits) - 1)) | cmf_pkg::CFG_W'($urandom << bits);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cmf_pkg::REG_MASK_SELECT:     mask_reg      = data[2:0];
      cmf_pkg::REG_IMAGE_WIDTH:     width_reg     = data[10:0];
      cmf_pkg::REG_IMAGE_HEIGHT:    height_reg    = data[12:0];
      cmf_pkg::REG_BYTES_PER_PIXEL: bpp_reg       = data[2:0];
      cmf_pkg::REG_MAX_LEVEL:       level_max_reg = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one input transfer; the model runs on acceptance and queues what it owes
  task automatic send_sample(input logic [7:0] smp, input logic sof,
                             input bit typed, input pixel_out_t typed_px);
    int gap;
    pixel_out_t px;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    stream_busy = 1'b1;
    if (convolve_sample(smp, sof, px)) pending_pixels.push_back(typed ? typed_px : px);
  endtask

  // One setting of all five registers, then whole frames of random content.
  // Frame start is flagged on the first frame; later frames may rely on the
  // counters wrapping. Stray start flags and a cut-short last frame give
  // broken sequences.
  task automatic run_frames(input int unsigned w_raw, input int unsigned h_raw,
                            input int unsigned b_raw, input int unsigned mask,
                            input int unsigned lmax, input int frames,
                            input int stray_per_mille, input bit cut_last,
                            input bit hold);
    int unsigned per_frame, stop;
    int f, i;
    bit binary;
    logic sof;
    logic [7:0] smp;
    pixel_out_t none;
    none = '0;
    write_reg(cmf_pkg::REG_MASK_SELECT, mask);
    write_reg(cmf_pkg::REG_IMAGE_WIDTH, w_raw);
    write_reg(cmf_pkg::REG_IMAGE_HEIGHT, h_raw);
    write_reg(cmf_pkg::REG_BYTES_PER_PIXEL, b_raw);
    write_reg(cmf_pkg::REG_MAX_LEVEL, lmax);
    if (hold) hold_request = 1'b1;
    per_frame = clamp_to(width_reg, 3, MAX_W) * clamp_to(height_reg, 3, MAX_H)
                * clamp_to(bpp_reg, 1, MAX_CH);
    for (f = 0; f < frames; f++) begin
      stop = per_frame;
      if (cut_last && f == frames - 1) stop = $urandom_range(1, per_frame);
      binary = ($urandom_range(0, 4) == 0);  // black/white frames hit the clamps
      for (i = 0; i < stop; i++) begin
        sof = (i == 0 && (f == 0 || $urandom_range(0, 1) == 1)) ||
              ($urandom_range(0, 999) < stray_per_mille);
        smp = binary ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
        send_sample(smp, sof, 1'b0, none);
        random_items++;
      end
    end
  endtask

  function automatic stim_row_t reg_row(cmf_pkg::reg_index_t idx, int unsigned value);
    stim_row_t row;
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.value  = value;
    row.sof    = 1'b0;
    row.typed  = 1'b0;
    row.px     = '0;
    return row;
  endfunction

  function automatic stim_row_t smp_row(logic [7:0] smp, logic sof);
    stim_row_t row;
    row.is_reg = 1'b0;
    row.idx    = cmf_pkg::REG_MASK_SELECT;
    row.value  = smp;
    row.sof    = sof;
    row.typed  = 1'b0;
    row.px     = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [7:0] smp, logic sof, pixel_out_t px);
    stim_row_t row;
    row       = smp_row(smp, sof);
    row.typed = 1'b1;
    row.px    = px;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transfer against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata};
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result: level %0d row %0d pos %0d last %0b",
                   $time, got.level, got.row, got.pos, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.level !== want.level || got.row !== want.row ||
            got.pos !== want.pos || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"%0t: mismatch: expected level %0d row %0d pos %0d last %0b,",
                      " got level %0d row %0d pos %0d last %0b"},
                     $time, want.level, want.row, want.pos, want.last,
                     got.level, got.row, got.pos, got.last);
        end
      end
    end
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("conv3x3_mask_filter_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t directed_rows[$];
    int unsigned w, h, b, lmax, pick;
    int phase, i;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= cmf_pkg::REG_MASK_SELECT;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;

    // Directed: 3x3 frames, one channel, so each frame yields exactly one
    // pixel (row 1, pos 1) that is also the last of its frame.
    directed_rows.push_back(reg_row(cmf_pkg::REG_IMAGE_WIDTH, 3));
    directed_rows.push_back(reg_row(cmf_pkg::REG_IMAGE_HEIGHT, 3));
    directed_rows.push_back(reg_row(cmf_pkg::REG_BYTES_PER_PIXEL, 1));
    directed_rows.push_back(reg_row(cmf_pkg::REG_MASK_SELECT, MASK_DIV9));
    directed_rows.push_back(reg_row(cmf_pkg::REG_MAX_LEVEL, 255));
    // flat full-scale field: the box mean is full scale
    for (i = 0; i < 8; i++) directed_rows.push_back(smp_row(8'hFF, i == 0));
    directed_rows.push_back(checked_row(8'hFF, 1'b0, '{1'b1, 12'd1, 12'd1, 8'd255}));
    // dark center on a bright field: sharpening goes negative, clamps to zero
    directed_rows.push_back(reg_row(cmf_pkg::REG_MASK_SELECT, MASK_SHARPEN1));
    for (i = 0; i < 8; i++) directed_rows.push_back(smp_row((i == 4) ? 8'h00 : 8'hFF, i == 0));
    directed_rows.push_back(checked_row(8'hFF, 1'b0, '{1'b1, 12'd1, 12'd1, 8'd0}));
    // no frame-start flag: counters wrapped at the end of the last frame;
    // bright center on black overshoots and clamps to max_level
    directed_rows.push_back(reg_row(cmf_pkg::REG_MASK_SELECT, MASK_SHARPEN2));
    directed_rows.push_back(reg_row(cmf_pkg::REG_MAX_LEVEL, 100));
    for (i = 0; i < 8; i++) directed_rows.push_back(smp_row((i == 4) ? 8'hFF : 8'h00, 1'b0));
    directed_rows.push_back(checked_row(8'h00, 1'b0, '{1'b1, 12'd1, 12'd1, 8'd100}));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 30;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].is_reg)
        write_reg(directed_rows[k].idx, directed_rows[k].value);
      else
        send_sample(8'(directed_rows[k].value), directed_rows[k].sof,
                    directed_rows[k].typed, directed_rows[k].px);
    end

    // Back-pressure: sender offers every cycle while the receiver holds off
    // long enough for the block to fill and drop s_tready.
    idle_pct = 0;
    run_frames(10, 6, 2, MASK_DIV16, 255, 1, 0, 1'b0, 1'b1);

    // Random frames: mostly small images; some register values out of range
    // to exercise the clamps. The first eight settings walk all masks.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      w = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      h = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(4, 7);
        b = (pick == 4) ? 0 : pick;
      end else begin
        b = $urandom_range(1, 4);
      end
      pick = $urandom_range(0, 9);
      lmax = (pick < 3) ? 255 : ((pick < 5) ? 0 : $urandom_range(0, 255));
      run_frames(w, h, b, (phase < 8) ? phase : $urandom_range(0, 7), lmax,
                 $urandom_range(1, 2), 20, ($urandom_range(0, 4) == 0), 1'b0);
      phase++;
    end

    quiesce();
    if (fail_count == 0)
      $display("conv3x3_mask_filter_unit test passed");
    else
      $display("conv3x3_mask_filter_unit test failed");
    $finish;
  end

endmodule
